// ----- hw/rtl/bgca_pkg.sv -----
// Shared types, widths and constants for the barometric ground-calibrated altitude unit.
// Also holds the elaboration-time routines that build the altitude node table.
// No dependencies.
package bgca_pkg;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned PA_W       = 17;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned Q_W        = PA_W + FRAC_BITS;  // Q17.8 pressure
  localparam int unsigned ALT_W      = 24;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned SEG_DEFAULT = 256;
  localparam int unsigned CAP_DEFAULT = 20;

  localparam logic [CNT_W-1:0] FULL_CAL_RESET   = CNT_W'(200);
  localparam logic [CNT_W-1:0] GROUND_LVL_RESET = CNT_W'(20);

  localparam int unsigned STD_PA    = 101325;
  localparam int          ALT_SCALE = 4433000;
  localparam logic [Q_W-1:0] GP_RESET = Q_W'(STD_PA << FRAC_BITS);

  localparam logic [CFG_IDX_W-1:0] REG_FULL_CAL   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUND_LVL = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE   = 2'd0,
    OP_FULL_CAL = 2'd1,
    OP_GROUND   = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_ALT_GO,
    ST_ALT_WAIT,
    ST_GND_GO,
    ST_GND_WAIT,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    LK_IDLE,
    LK_DIFF,
    LK_MUL,
    LK_SUM,
    LK_DONE
  } lk_state_t;

  localparam logic [63:0]        Q30_ONE  = 64'd1 << 30;
  localparam logic signed [63:0] LN2_Q30  = 64'sd744261118;
  localparam logic [63:0]        EXPO_Q30 = 64'd204327700;

  // Unsigned 64-bit quotient by shift and subtract, one bit per step.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Natural log in Q30 via range reduction and the atanh series.
  function automatic logic signed [63:0] ln_q30(input logic [63:0] t_in);
    logic [63:0]        t;
    logic [63:0]        y;
    logic [63:0]        y2;
    logic [63:0]        pw;
    logic [63:0]        sum;
    logic signed [63:0] k;
    t   = t_in;
    k   = '0;
    sum = '0;
    for (int s = 0; s < 64; s++) begin
      if (t < Q30_ONE) begin
        t = t << 1;
        k = k - 64'sd1;
      end
    end
    for (int s = 0; s < 64; s++) begin
      if (t >= (Q30_ONE << 1)) begin
        t = t >> 1;
        k = k + 64'sd1;
      end
    end
    y  = udiv64((t - Q30_ONE) << 30, t + Q30_ONE);
    y2 = (y * y) >> 30;
    pw = y;
    for (int unsigned n = 1; n < 64; n += 2) begin
      if (pw != 0) begin
        sum = sum + udiv64(pw, 64'(n));
        pw  = (pw * y2) >> 30;
      end
    end
    return k * LN2_Q30 + $signed(sum << 1);
  endfunction

  // e^z for z >= 0, Taylor series in Q30.
  function automatic logic [63:0] exp_pos_q30(input logic [63:0] z);
    logic [63:0] sum;
    logic [63:0] term;
    logic        stop;
    sum  = Q30_ONE;
    term = Q30_ONE;
    stop = 1'b0;
    for (int unsigned n = 1; n < 60; n++) begin
      if (!stop) begin
        term = udiv64((term * z) >> 30, 64'(n));
        if (term == 0) stop = 1'b1;
        else sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Altitude in cm at node i of a table with seg segments over 0..131072 Pa.
  function automatic logic signed [ALT_W-1:0] node_altitude(input logic [63:0] i,
                                                             input logic [63:0] seg);
    logic [63:0]        den;
    logic [63:0]        t;
    logic [63:0]        mag;
    logic [63:0]        zm;
    logic [63:0]        e;
    logic [63:0]        am;
    logic signed [63:0] lx;
    logic signed [63:0] diff;
    den = seg * 64'(STD_PA);
    if (i == 0) return ALT_W'(ALT_SCALE);
    t = udiv64(i << 47, den);
    if (t == 0) return ALT_W'(ALT_SCALE);
    lx  = ln_q30(t);
    mag = (lx < 0) ? 64'(-lx) : 64'(lx);
    zm  = (mag * EXPO_Q30) >> 30;
    e   = exp_pos_q30(zm);
    if (lx < 0) e = udiv64(64'd1 << 60, e);
    diff = $signed(Q30_ONE) - $signed(e);
    mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
    am   = (mag * 64'(ALT_SCALE) + (64'd1 << 29)) >> 30;
    return (diff < 0) ? ALT_W'(-$signed(am)) : ALT_W'(am);
  endfunction

endpackage

// ----- hw/rtl/bgca_ifs.sv -----
// Valid/ready channel interfaces of the altitude unit: sample, result and register write.
// Depends on bgca_pkg for payload widths.
interface bgca_sample_if;
  import bgca_pkg::*;
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] op;
  logic [PA_W-1:0] pressure_pa;
  modport source (output valid, op, pressure_pa, input ready);
  modport sink   (input valid, op, pressure_pa, output ready);
endinterface

interface bgca_result_if;
  import bgca_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ALT_W-1:0] altitude_cm;
  logic                    calibrating;
  logic                    ready_res;
  modport source (output valid, altitude_cm, calibrating, ready_res, input ready);
  modport sink   (input valid, altitude_cm, calibrating, ready_res, output ready);
endinterface

interface bgca_cfg_if;
  import bgca_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/baro_ground_calibrated_altitude_unit.sv -----
// Barometric altitude above a calibrated ground reference, top level.
// Each pressure beat runs through the 25-step serial interpolation multiplier or the 26-step
//   serial divider, then its result is loaded into the output register.
// Throughput: one pressure beat in flight; the next is taken once its result enters the output
//   register, which waits while the result side stalls; command beats give no result.
// Reset (rst, synchronous): registers to 200/20, ground pressure 101325 Pa, no calibration.
module baro_ground_calibrated_altitude_unit #(
  parameter int unsigned TABLE_SEGMENTS  = bgca_pkg::SEG_DEFAULT,
  parameter int unsigned AVG_DIVISOR_CAP = bgca_pkg::CAP_DEFAULT
) (
  input logic           clk,
  input logic           rst,
  bgca_sample_if.sink   sample,
  bgca_result_if.source result,
  bgca_cfg_if.sink      cfg
);
  import bgca_pkg::*;

  localparam int unsigned N_W = $clog2(AVG_DIVISOR_CAP + 1);
  localparam int unsigned D_W = Q_W + 1;  // |pressure diff| plus rounding half

  localparam logic signed [ALT_W:0] SAT_HI = (ALT_W + 1)'(ALT_SCALE);
  localparam logic signed [ALT_W:0] SAT_LO = -SAT_HI;

  state_t state;
  state_t state_next;

  // Configuration and calibration state
  logic [CNT_W-1:0]        full_calib_samples;
  logic [CNT_W-1:0]        ground_level_samples;
  logic [Q_W-1:0]          ground_pressure;
  logic signed [ALT_W-1:0] ground_altitude;
  logic [CNT_W-1:0]        samples_required;
  logic [CNT_W-1:0]        sample_count;
  logic                    cal_done;

  // Per-item working registers
  logic [Q_W-1:0]          q_r;
  logic [D_W-1:0]          diff_r;
  logic [N_W-1:0]          n_r;
  logic [D_W-1:0]          dvd_r;
  logic                    neg_r;
  logic signed [ALT_W-1:0] res_alt;

  // Output register
  logic                    out_valid;
  logic signed [ALT_W-1:0] out_alt;
  logic                    out_cal;
  logic                    out_rdy;

  logic                    accept;
  logic                    out_free;
  logic                    emit;
  logic                    lk_start;
  logic                    lk_done;
  logic signed [ALT_W-1:0] lk_alt;
  logic                    div_start;
  logic                    div_done;
  logic [D_W-1:0]          quot;
  logic                    cal_idle;
  logic                    cal_end;
  logic [Q_W-1:0]          sample_q;
  logic signed [ALT_W:0]   rel;

  // Hold off both input channels while reset is applied.
  assign cfg.ready = !rst;
  assign accept    = sample.valid && sample.ready;
  assign out_free  = !out_valid || result.ready;

  assign cal_idle = samples_required == '0;
  assign cal_end  = sample_count >= samples_required;
  assign sample_q = {sample.pressure_pa, FRAC_BITS'(0)};

  // Altitude relative to ground, one subtract before saturation
  assign rel = {lk_alt[ALT_W-1], lk_alt} - {ground_altitude[ALT_W-1], ground_altitude};

  bgca_lookup #(
    .TABLE_SEGMENTS (TABLE_SEGMENTS)
  ) u_lookup (
    .clk   (clk),
    .rst   (rst),
    .start (lk_start),
    .q     (q_r),
    .done  (lk_done),
    .alt   (lk_alt)
  );

  bgca_serial_div #(
    .D_W (D_W),
    .N_W (N_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd_r),
    .divisor  (n_r),
    .done     (div_done),
    .quotient (quot)
  );

  // Next state: a pressure beat picks one of three paths from the calibration state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (sample.valid && sample.op == OP_SAMPLE) begin
          if (cal_idle) state_next = ST_ALT_GO;
          else if (cal_end) state_next = ST_GND_GO;
          else state_next = ST_PREP;
        end
      end
      ST_PREP:     state_next = ST_DIV_GO;
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_next = ST_EMIT;
      ST_ALT_GO:   state_next = ST_ALT_WAIT;
      ST_ALT_WAIT: if (lk_done) state_next = ST_EMIT;
      ST_GND_GO:   state_next = ST_GND_WAIT;
      ST_GND_WAIT: if (lk_done) state_next = ST_EMIT;
      ST_EMIT:     if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Strobes: take sample beats only when idle; the output register decouples the result side.
  always_comb begin
    sample.ready = 1'b0;
    lk_start     = 1'b0;
    div_start    = 1'b0;
    emit         = 1'b0;
    unique case (state)
      ST_IDLE:   sample.ready = !rst;
      ST_DIV_GO: div_start    = 1'b1;
      ST_ALT_GO: lk_start     = 1'b1;
      ST_GND_GO: lk_start     = 1'b1;
      ST_EMIT:   emit         = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= ST_IDLE;
      full_calib_samples   <= FULL_CAL_RESET;
      ground_level_samples <= GROUND_LVL_RESET;
      ground_pressure      <= GP_RESET;
      ground_altitude      <= '0;
      samples_required     <= '0;
      sample_count         <= '0;
      cal_done             <= 1'b0;
      out_valid            <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg.valid) begin
        unique case (cfg.index)
          REG_FULL_CAL:   full_calib_samples   <= cfg.data;
          REG_GROUND_LVL: ground_level_samples <= cfg.data;
        endcase
      end

      if (emit) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          // Commands reload the target count and keep the running sample count.
          if (accept) begin
            unique case (sample.op)
              OP_FULL_CAL: samples_required <= full_calib_samples;
              OP_GROUND:   samples_required <= ground_level_samples;
              default: ;
            endcase
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            ground_pressure <= neg_r ? Q_W'(D_W'(ground_pressure) - quot)
                                     : Q_W'(D_W'(ground_pressure) + quot);
            sample_count    <= sample_count + CNT_W'(1);
          end
        end
        ST_GND_WAIT: begin
          // Calibration ends: freeze the ground altitude and clear the request.
          if (lk_done) begin
            ground_altitude  <= lk_alt;
            samples_required <= '0;
            sample_count     <= '0;
            cal_done         <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r    <= cal_idle ? sample_q : ground_pressure;
      diff_r <= {1'b0, sample_q} - {1'b0, ground_pressure};
      n_r    <= (sample_count >= CNT_W'(AVG_DIVISOR_CAP)) ? N_W'(AVG_DIVISOR_CAP)
                                                           : N_W'(sample_count + CNT_W'(1));
    end
    if (state == ST_PREP) begin
      // |diff| + n/2 in one add: for a negative diff use ~diff + 1.
      neg_r <= diff_r[D_W-1];
      dvd_r <= diff_r[D_W-1] ? (~diff_r) + D_W'(n_r >> 1) + D_W'(1)
                             : diff_r + D_W'(n_r >> 1);
    end
    if (state == ST_ALT_WAIT && lk_done) begin
      if (rel > SAT_HI) res_alt <= ALT_W'(SAT_HI);
      else if (rel < SAT_LO) res_alt <= ALT_W'(SAT_LO);
      else res_alt <= ALT_W'(rel);
    end else if ((state == ST_DIV_WAIT && div_done) || (state == ST_GND_WAIT && lk_done)) begin
      res_alt <= '0;
    end
    if (emit) begin
      out_alt <= res_alt;
      out_cal <= !cal_idle;
      out_rdy <= cal_done && cal_idle;
    end
  end

  assign result.valid       = out_valid;
  assign result.altitude_cm = out_alt;
  assign result.calibrating = out_cal;
  assign result.ready_res   = out_rdy;

endmodule

// ----- hw/rtl/bgca_serial_mul.sv -----
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// Returns the product shifted right by B_W and the next lower bit for rounding.
module bgca_serial_mul #(
  parameter int unsigned A_W = 24,
  parameter int unsigned B_W = 25
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  output logic           done,
  output logic [A_W-1:0] hi,
  output logic           rnd
);
  localparam int unsigned C_W = $clog2(B_W + 1);

  logic           running;
  logic [C_W-1:0] cnt;
  logic [A_W-1:0] areg;
  logic [A_W-1:0] acc;
  logic [B_W-1:0] breg;
  logic [A_W:0]   sum;

  assign sum = {1'b0, acc} + (breg[0] ? {1'b0, areg} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == C_W'(1));
      if (start) begin
        running <= 1'b1;
        cnt     <= C_W'(B_W);
      end else if (running) begin
        cnt <= cnt - C_W'(1);
        if (cnt == C_W'(1)) running <= 1'b0;
      end
    end
  end

  // Product lives in {acc, breg}; shift right one bit per step.
  always_ff @(posedge clk) begin
    if (start) begin
      areg <= a;
      acc  <= '0;
      breg <= b;
    end else if (running) begin
      acc  <= sum[A_W:1];
      breg <= {sum[0], breg[B_W-1:1]};
    end
  end

  assign hi  = acc;
  assign rnd = breg[B_W-1];

endmodule

// ----- hw/rtl/bgca_serial_div.sv -----
// Restoring bit-serial divider: one quotient bit per cycle.
// Divisor must be nonzero; no dependencies.
module bgca_serial_div #(
  parameter int unsigned D_W = 26,
  parameter int unsigned N_W = 5
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [D_W-1:0] dividend,
  input  logic [N_W-1:0] divisor,
  output logic           done,
  output logic [D_W-1:0] quotient
);
  localparam int unsigned C_W = $clog2(D_W + 1);

  logic           running;
  logic [C_W-1:0] cnt;
  logic [N_W-1:0] dvs;
  logic [N_W-1:0] rem;
  logic [D_W-1:0] qreg;
  logic [N_W:0]   rem_sh;
  logic           ge;

  assign rem_sh = {rem, qreg[D_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == C_W'(1));
      if (start) begin
        running <= 1'b1;
        cnt     <= C_W'(D_W);
      end else if (running) begin
        cnt <= cnt - C_W'(1);
        if (cnt == C_W'(1)) running <= 1'b0;
      end
    end
  end

  // Dividend bits shift out the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      dvs  <= divisor;
      rem  <= '0;
      qreg <= dividend;
    end else if (running) begin
      rem  <= ge ? N_W'(rem_sh - {1'b0, dvs}) : rem_sh[N_W-1:0];
      qreg <= {qreg[D_W-2:0], ge};
    end
  end

  assign quotient = qreg;

endmodule

// ----- hw/rtl/bgca_lookup.sv -----
// Altitude lookup: constant node table plus linear interpolation on a serial multiplier.
// Depends on bgca_pkg and bgca_serial_mul.
module bgca_lookup #(
  parameter int unsigned TABLE_SEGMENTS = bgca_pkg::SEG_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [bgca_pkg::Q_W-1:0]          q,
  output logic                              done,
  output logic signed [bgca_pkg::ALT_W-1:0] alt
);
  import bgca_pkg::*;

  localparam int unsigned TIDX_W = $clog2(TABLE_SEGMENTS + 1);
  localparam int unsigned POS_W  = Q_W + TIDX_W;

  lk_state_t state;
  lk_state_t state_next;

  logic signed [ALT_W-1:0] node_alt [0:TABLE_SEGMENTS];

  for (genvar g = 0; g <= TABLE_SEGMENTS; g++) begin : g_node
    localparam logic signed [ALT_W-1:0] NODE = node_altitude(64'(g), 64'(TABLE_SEGMENTS));
    assign node_alt[g] = NODE;
  end

  logic [POS_W-1:0]        pos;
  logic [TIDX_W-1:0]       idx;
  logic [TIDX_W-1:0]       idx_hi;
  logic signed [ALT_W-1:0] a_r;
  logic signed [ALT_W-1:0] b_r;
  logic [Q_W-1:0]          frac_r;
  logic                    neg;
  logic                    neg_r;
  logic [ALT_W-1:0]        mag;
  logic [ALT_W-1:0]        adj_r;
  logic signed [ALT_W-1:0] alt_r;
  logic                    load_nodes;
  logic                    mul_start;
  logic                    mul_done;
  logic [ALT_W-1:0]        mul_hi;
  logic                    mul_rnd;

  // Position in segments; q stays below 2^25, so idx never passes the last segment.
  assign pos    = POS_W'(q) * POS_W'(TABLE_SEGMENTS);
  assign idx    = pos[POS_W-1:Q_W];
  assign idx_hi = idx + TIDX_W'(1);

  assign neg = b_r < a_r;
  assign mag = neg ? ALT_W'(a_r - b_r) : ALT_W'(b_r - a_r);

  bgca_serial_mul #(
    .A_W (ALT_W),
    .B_W (Q_W)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mag),
    .b     (frac_r),
    .done  (mul_done),
    .hi    (mul_hi),
    .rnd   (mul_rnd)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      LK_IDLE: if (start) state_next = LK_DIFF;
      LK_DIFF: state_next = LK_MUL;
      LK_MUL:  if (mul_done) state_next = LK_SUM;
      LK_SUM:  state_next = LK_DONE;
      LK_DONE: state_next = LK_IDLE;
      default: state_next = LK_IDLE;
    endcase
  end

  always_comb begin
    load_nodes = 1'b0;
    mul_start  = 1'b0;
    done       = 1'b0;
    unique case (state)
      LK_IDLE: load_nodes = start;
      LK_DIFF: mul_start  = 1'b1;
      LK_DONE: done       = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= LK_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (load_nodes) begin
      a_r    <= node_alt[idx];
      b_r    <= node_alt[idx_hi];
      frac_r <= pos[Q_W-1:0];
    end
    if (mul_start) neg_r <= neg;
    if (state == LK_MUL && mul_done) adj_r <= mul_hi + ALT_W'(mul_rnd);
    if (state == LK_SUM) begin
      alt_r <= neg_r ? ALT_W'({a_r[ALT_W-1], a_r} - {1'b0, adj_r})
                     : ALT_W'({a_r[ALT_W-1], a_r} + {1'b0, adj_r});
    end
  end

  assign alt = alt_r;

endmodule

// ----- hw/rtl/bgca_checker.sv -----
// Port-level checks for the altitude unit, bound to the top level.
// Depends on bgca_pkg.
module bgca_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              sample_valid,
  input logic                              sample_ready,
  input logic [bgca_pkg::OP_W-1:0]         sample_op,
  input logic                              result_valid,
  input logic                              result_ready,
  input logic signed [bgca_pkg::ALT_W-1:0] result_alt,
  input logic                              result_cal,
  input logic                              result_rdy
);
  import bgca_pkg::*;

  localparam logic signed [ALT_W-1:0] ALT_MAX = ALT_W'(ALT_SCALE);

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_alt)
      && $stable(result_cal) && $stable(result_rdy))
    else $error("result beat changed while stalled");

  a_busy_after_sample: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready && sample_op == OP_SAMPLE |=> !sample_ready)
    else $error("sample taken while a pressure beat is in flight");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result_cal && result_rdy))
    else $error("calibrating and ready both set");

  a_zero_while_cal: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_cal |-> result_alt == '0)
    else $error("nonzero altitude while calibrating");

  a_saturated: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_alt <= ALT_MAX) && (result_alt >= -ALT_MAX))
    else $error("altitude outside saturation range");

endmodule

bind baro_ground_calibrated_altitude_unit bgca_checker u_bgca_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample.valid),
  .sample_ready (sample.ready),
  .sample_op    (sample.op),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_alt   (result.altitude_cm),
  .result_cal   (result.calibrating),
  .result_rdy   (result.ready_res)
);
